// File: design/assert_macros.svh
// Assertion macros shared by the battery reading supervisor RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BRS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/brs_pkg.sv
// Package of the battery reading supervisor: widths, codes, payload types
// and the two fixed-point charge curves. Depends on nothing.
`default_nettype none

package brs_pkg;

  localparam int MV_W       = 13;
  localparam int SOC_W      = 10;
  localparam int CTX_W      = 3;
  localparam int CAP_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Status codes of charge, voltage and context.
  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_UNKNOWN  = 2'd1;
  localparam logic [1:0] ST_NA       = 2'd2;
  localparam logic [1:0] ST_FALLBACK = 2'd3;

  // Charger context codes.
  localparam logic [CTX_W-1:0] CTX_UNKNOWN      = 3'd0;
  localparam logic [CTX_W-1:0] CTX_NOT_CHARGING = 3'd1;
  localparam logic [CTX_W-1:0] CTX_CHARGING     = 3'd2;
  localparam logic [CTX_W-1:0] CTX_CHARGED      = 3'd3;
  localparam logic [CTX_W-1:0] CTX_DISCHARGING  = 3'd4;
  localparam logic [CTX_W-1:0] CTX_FAULT        = 3'd5;
  localparam logic [CTX_W-1:0] CTX_DISCONNECTED = 3'd6;
  localparam logic [CTX_W-1:0] CTX_NA           = 3'd7;

  // Power modes.
  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_CONSERVE = 2'd1;
  localparam logic [1:0] MODE_CRITICAL = 2'd2;
  localparam logic [1:0] MODE_SURVIVAL = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CAPABILITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONSERVE_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOVERY_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POWERDOWN_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_VOLTAGE = 3'd6;

  // Register reset values.
  localparam logic [CAP_W-1:0] RST_CAPABILITY    = 3'd5;
  localparam logic [SOC_W-1:0] RST_NORMAL_MIN    = 10'd600;
  localparam logic [SOC_W-1:0] RST_CONSERVE_MIN  = 10'd400;
  localparam logic [SOC_W-1:0] RST_CRITICAL_MIN  = 10'd200;
  localparam logic [SOC_W-1:0] RST_DISCOVERY_MIN = 10'd500;
  localparam logic [SOC_W-1:0] RST_POWERDOWN_MIN = 10'd300;
  localparam logic [MV_W-1:0]  RST_FULL_VOLTAGE  = 13'd4150;

  // Voltage window and charge limits.
  localparam logic [MV_W-1:0]  MV_MIN        = 13'd3000;
  localparam logic [MV_W-1:0]  MV_MAX        = 13'd4500;
  localparam logic [MV_W-1:0]  MV_EMPTY_SUSP = 13'd3450;
  localparam logic [SOC_W-1:0] SOC_FULL      = 10'd1000;

  typedef struct packed {
    logic [MV_W-1:0]  voltage_mv;
    logic             voltage_missing;
    logic [SOC_W-1:0] gauge_soc;
    logic             gauge_missing;
    logic [CTX_W-1:0] charger_state;
  } in_item_t;

  typedef struct packed {
    logic [SOC_W-1:0] soc_tenths;
    logic [1:0]       soc_status;
    logic [MV_W-1:0]  battery_mv;
    logic [1:0]       battery_mv_status;
    logic [CTX_W-1:0] battery_context;
    logic [1:0]       context_status;
    logic [1:0]       power_mode;
    logic             allow_discovery;
    logic             allow_powerdown;
    logic             reduced_retry;
    logic             long_sleep;
    logic             soc_from_fallback;
  } out_item_t;

  typedef struct packed {
    logic [CAP_W-1:0] capability_flags;
    logic [SOC_W-1:0] normal_min_soc;
    logic [SOC_W-1:0] conserve_min_soc;
    logic [SOC_W-1:0] critical_min_soc;
    logic [SOC_W-1:0] discovery_min_soc;
    logic [SOC_W-1:0] powerdown_min_soc;
    logic [MV_W-1:0]  full_voltage_mv;
  } cfg_t;

  // A classified sample as it travels from the front to the back.
  typedef struct packed {
    logic [SOC_W-1:0] soc;
    logic [1:0]       soc_st;
    logic [MV_W-1:0]  mv;
    logic [1:0]       mv_st;
    logic [CTX_W-1:0] ctx;
    logic [1:0]       ctx_st;
    logic             susp;
    logic [SOC_W-1:0] cons_soc;
  } cls_t;

  // Truncating division by three for values up to 600, by reciprocal.
  function automatic logic [SOC_W-1:0] div3(input logic [SOC_W-1:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return 10'(p[19:11]);
  endfunction

  // Charge estimate from voltage when there is no gauge.
  function automatic logic [SOC_W-1:0] curve_soc(input logic [MV_W-1:0] mv);
    logic [MV_W-1:0] d;
    logic [SOC_W-1:0] r;
    d = '0;
    if (mv <= 13'd3300) begin
      r = '0;
    end else if (mv <= 13'd3600) begin
      d = mv - 13'd3300;
      r = div3(10'(d << 1));
    end else if (mv <= 13'd3800) begin
      d = mv - 13'd3600;
      r = 10'(13'd200 + (d << 1));
    end else if (mv <= 13'd4000) begin
      d = mv - 13'd3800;
      r = 10'(13'd600 + (13'(d * 13'd5) >> 2));
    end else if (mv <= 13'd4200) begin
      d = mv - 13'd4000;
      r = 10'(13'd850 + (13'(d * 13'd3) >> 2));
    end else begin
      r = SOC_FULL;
    end
    return r;
  endfunction

  // Conservative fallback estimate from voltage.
  function automatic logic [SOC_W-1:0] cons_curve(input logic [MV_W-1:0] mv);
    logic [MV_W-1:0] d;
    logic [SOC_W-1:0] r;
    d = '0;
    if (mv <= 13'd3500) begin
      r = 10'd100;
    end else if (mv >= 13'd4180) begin
      r = 10'd980;
    end else if (mv <= 13'd3700) begin
      d = mv - 13'd3500;
      r = 10'(13'd100 + (13'(d * 13'd3) >> 1));
    end else if (mv <= 13'd3850) begin
      d = mv - 13'd3700;
      r = 10'(10'd400 + div3(10'(d << 2)));
    end else if (mv <= 13'd4000) begin
      d = mv - 13'd3850;
      r = 10'(10'd600 + div3(10'(d << 2)));
    end else if (mv <= 13'd4100) begin
      d = mv - 13'd4000;
      r = 10'(13'd800 + d);
    end else begin
      d = mv - 13'd4100;
      r = 10'(13'd900 + d);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: design/brs_sample_if.sv
// Sample channel of the battery reading supervisor: valid, ready, payload.
// Depends on brs_pkg.
`default_nettype none

interface brs_sample_if;
  logic              valid;
  logic              ready;
  brs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/brs_reading_if.sv
// Reading channel of the battery reading supervisor: valid, ready, payload.
// Depends on brs_pkg.
`default_nettype none

interface brs_reading_if;
  logic               valid;
  logic               ready;
  brs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/brs_front.sv
// Front of the supervisor: accepts a sample and classifies it without state.
// Depends on brs_pkg and brs_sample_if.
`default_nettype none

module brs_front (
  input  brs_pkg::cfg_t cfg,
  brs_sample_if.sink    samples,
  input  logic          q_full,
  output logic          push,
  output brs_pkg::cls_t cls
);
  import brs_pkg::*;

  logic has_gauge, has_adc, has_ctx, has_meas;
  logic mv_ok, soc_nan, full, charged, odd;
  in_item_t s;

  assign samples.ready = !q_full;
  assign push          = samples.valid && !q_full;
  assign s             = samples.data;

  assign has_gauge = cfg.capability_flags[0];
  assign has_adc   = cfg.capability_flags[1];
  assign has_ctx   = cfg.capability_flags[2];
  assign has_meas  = has_gauge || has_adc;

  always_comb begin
    mv_ok = !s.voltage_missing && s.voltage_mv >= MV_MIN && s.voltage_mv <= MV_MAX;

    // Voltage.
    if (mv_ok) begin
      cls.mv    = s.voltage_mv;
      cls.mv_st = ST_VALID;
    end else if (has_meas) begin
      cls.mv    = s.voltage_missing ? '0 : s.voltage_mv;
      cls.mv_st = ST_UNKNOWN;
    end else begin
      cls.mv    = '0;
      cls.mv_st = ST_NA;
    end

    // Charge.
    if (has_gauge) begin
      cls.soc    = s.gauge_missing ? '0 : s.gauge_soc;
      soc_nan    = s.gauge_missing;
      cls.soc_st = (!s.gauge_missing && s.gauge_soc <= SOC_FULL) ? ST_VALID : ST_UNKNOWN;
    end else if (has_adc && mv_ok) begin
      cls.soc    = curve_soc(s.voltage_mv);
      soc_nan    = 1'b0;
      cls.soc_st = ST_VALID;
    end else begin
      cls.soc    = '0;
      soc_nan    = 1'b1;
      cls.soc_st = ST_NA;
    end

    // Charger context.
    if (has_ctx) begin
      cls.ctx    = (s.charger_state inside {[CTX_NOT_CHARGING:CTX_DISCONNECTED]})
                   ? s.charger_state : CTX_UNKNOWN;
      cls.ctx_st = (cls.ctx == CTX_UNKNOWN) ? ST_UNKNOWN : ST_VALID;
    end else begin
      cls.ctx    = CTX_NA;
      cls.ctx_st = ST_NA;
    end

    // An empty or full reading that voltage or charger state contradicts.
    full    = cls.mv_st == ST_VALID && cls.mv >= cfg.full_voltage_mv;
    charged = cls.ctx_st == ST_VALID && cls.ctx == CTX_CHARGED;
    odd     = cls.ctx_st != ST_VALID ||
              (cls.ctx inside {CTX_UNKNOWN, CTX_NOT_CHARGING, CTX_CHARGING,
                               CTX_DISCHARGING, CTX_FAULT});
    cls.susp = 1'b0;
    if (!soc_nan && cls.soc == '0) begin
      cls.susp = (cls.mv_st == ST_VALID && cls.mv > MV_EMPTY_SUSP) ||
                 (cls.ctx_st == ST_VALID &&
                  !(cls.ctx inside {CTX_DISCHARGING, CTX_FAULT, CTX_DISCONNECTED}));
    end else if (!soc_nan && cls.soc == SOC_FULL) begin
      cls.susp = !full && (odd || charged);
    end

    cls.cons_soc = cons_curve(cls.mv);
  end

endmodule

`default_nettype wire

// File: design/brs_queue.sv
// Short queue of classified samples between the front and the back.
// Depends on brs_pkg.
`default_nettype none

module brs_queue #(
  parameter int Depth = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  brs_pkg::cls_t push_data,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output brs_pkg::cls_t head,
  output logic [$clog2(Depth+1)-1:0] count
);
  import brs_pkg::*;

  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cls_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;

  assign full       = count == CountW'(Depth);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/brs_back.sv
// Back of the supervisor: fallback from last-known-good values, power policy
// and the output register. Depends on brs_pkg and brs_reading_if.
`default_nettype none

module brs_back (
  input  logic          clk,
  input  logic          rst,
  input  brs_pkg::cfg_t cfg,
  input  logic          head_valid,
  input  brs_pkg::cls_t head,
  output logic          pop,
  brs_reading_if.source readings
);
  import brs_pkg::*;

  logic [SOC_W-1:0] good_soc;
  logic             good_soc_valid;
  logic [MV_W-1:0]  good_voltage;
  logic             good_voltage_valid;
  logic [CTX_W-1:0] good_context;

  logic             out_valid;
  out_item_t        out_data;
  out_item_t        res;

  logic             trig, used_fb, usable;
  logic [SOC_W-1:0] soc;
  logic [1:0]       soc_st;

  assign pop            = head_valid && (!out_valid || readings.ready);
  assign readings.valid = out_valid;
  assign readings.data  = out_data;

  always_comb begin
    trig    = head.soc_st == ST_UNKNOWN || head.susp;
    used_fb = 1'b0;
    soc     = head.soc;
    soc_st  = head.soc_st;
    res.battery_mv        = head.mv;
    res.battery_mv_status = head.mv_st;
    res.battery_context   = head.ctx;
    res.context_status    = head.ctx_st;

    if (trig) begin
      if (good_soc_valid) begin
        soc     = good_soc;
        soc_st  = ST_FALLBACK;
        used_fb = 1'b1;
      end else if (head.mv_st == ST_VALID) begin
        soc     = head.cons_soc;
        soc_st  = ST_FALLBACK;
        used_fb = 1'b1;
      end
      if (head.mv_st == ST_UNKNOWN && good_voltage_valid) begin
        res.battery_mv        = good_voltage;
        res.battery_mv_status = ST_FALLBACK;
      end
      if (head.ctx_st == ST_UNKNOWN && good_context != CTX_UNKNOWN) begin
        res.battery_context = good_context;
        res.context_status  = ST_FALLBACK;
      end
      // A measurement was there, but neither a stored nor an estimated
      // value could stand in for it.
      if (!used_fb) begin
        soc_st = ST_UNKNOWN;
      end
    end

    usable = soc_st == ST_VALID || soc_st == ST_FALLBACK;

    res.power_mode      = MODE_SURVIVAL;
    res.allow_discovery = 1'b0;
    res.allow_powerdown = 1'b0;
    if (usable) begin
      if (soc >= cfg.normal_min_soc) begin
        res.power_mode = MODE_NORMAL;
      end else if (soc >= cfg.conserve_min_soc) begin
        res.power_mode = MODE_CONSERVE;
      end else if (soc >= cfg.critical_min_soc) begin
        res.power_mode = MODE_CRITICAL;
      end
      res.allow_discovery = (soc_st == ST_VALID && soc >= cfg.discovery_min_soc) ||
                            (soc_st == ST_FALLBACK && soc >= cfg.normal_min_soc);
      res.allow_powerdown = soc_st == ST_VALID && soc >= cfg.powerdown_min_soc;
    end

    res.soc_tenths        = usable ? soc : '0;
    res.soc_status        = soc_st;
    res.reduced_retry     = res.power_mode == MODE_CRITICAL ||
                            res.power_mode == MODE_SURVIVAL;
    res.long_sleep        = res.reduced_retry;
    res.soc_from_fallback = used_fb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid          <= 1'b0;
      good_soc           <= '0;
      good_soc_valid     <= 1'b0;
      good_voltage       <= '0;
      good_voltage_valid <= 1'b0;
      good_context       <= CTX_UNKNOWN;
    end else begin
      if (pop) begin
        out_valid <= 1'b1;
      end else if (readings.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (head.soc_st == ST_VALID && !head.susp) begin
          good_soc       <= head.soc;
          good_soc_valid <= 1'b1;
        end
        if (head.mv_st == ST_VALID) begin
          good_voltage       <= head.mv;
          good_voltage_valid <= 1'b1;
        end
        if (head.ctx_st == ST_VALID) begin
          good_context <= head.ctx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: design/battery_reading_supervisor_unit.sv
// Top level of the battery reading supervisor: configuration registers,
// front, queue and back. Depends on brs_pkg, both channel interfaces,
// brs_front, brs_queue, brs_back and assert_macros.svh.
//
//   Channel    Direction  Handshake     Carries
//   samples    in         valid/ready   voltage, gauge charge, charger state
//   readings   out        valid/ready   cleaned reading and power policy
//   cfg_*      in         write enable  seven configuration registers
//
// One sample per clock is sustained while readings is ready; once its sample
// is accepted, a reading passes through the queue, then the output register.
// The back stage resolves fallbacks against the last-known-good registers
// once per cycle. Reset is synchronous; no clearing pass.
// When readings stalls, the queue soaks up QueueDepth samples before
// samples.ready drops.
`default_nettype none
`include "assert_macros.svh"

module battery_reading_supervisor_unit #(
  parameter int QueueDepth = 2
) (
  input  logic clk,
  input  logic rst,
  brs_sample_if.sink    samples,
  brs_reading_if.source readings,
  input  logic                               cfg_we,
  input  logic [brs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [brs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import brs_pkg::*;

  localparam int CountW = $clog2(QueueDepth + 1);

  cfg_t              cfg;
  cls_t              cls, head;
  logic              push, pop, q_full, head_valid;
  logic [CountW-1:0] q_count;

  // Configuration registers. The user must write them only while the block is idle,
  // so both halves may read them combinationally; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capability_flags  <= RST_CAPABILITY;
      cfg.normal_min_soc    <= RST_NORMAL_MIN;
      cfg.conserve_min_soc  <= RST_CONSERVE_MIN;
      cfg.critical_min_soc  <= RST_CRITICAL_MIN;
      cfg.discovery_min_soc <= RST_DISCOVERY_MIN;
      cfg.powerdown_min_soc <= RST_POWERDOWN_MIN;
      cfg.full_voltage_mv   <= RST_FULL_VOLTAGE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPABILITY:    cfg.capability_flags  <= cfg_data[CAP_W-1:0];
        REG_NORMAL_MIN:    cfg.normal_min_soc    <= cfg_data[SOC_W-1:0];
        REG_CONSERVE_MIN:  cfg.conserve_min_soc  <= cfg_data[SOC_W-1:0];
        REG_CRITICAL_MIN:  cfg.critical_min_soc  <= cfg_data[SOC_W-1:0];
        REG_DISCOVERY_MIN: cfg.discovery_min_soc <= cfg_data[SOC_W-1:0];
        REG_POWERDOWN_MIN: cfg.powerdown_min_soc <= cfg_data[SOC_W-1:0];
        REG_FULL_VOLTAGE:  cfg.full_voltage_mv   <= cfg_data[MV_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The front classifies each transaction on the samples channel with no
  // dependence on history; it waits only when the queue is full.
  brs_front u_front (
    .cfg     (cfg),
    .samples (samples),
    .q_full  (q_full),
    .push    (push),
    .cls     (cls)
  );

  brs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (cls),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .count      (q_count)
  );

  // The back applies fallbacks in order, updates the last-known-good
  // registers and holds each reading until its transaction completes.
  brs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .readings   (readings)
  );

  `BRS_ASSERT_SAME(a_fallback_status, clk, rst,
    readings.valid && readings.data.soc_from_fallback,
    readings.data.soc_status == ST_FALLBACK,
    "fallback flag set without fallback charge status")
  `BRS_ASSERT_SAME(a_absent_is_survival, clk, rst,
    readings.valid && readings.data.soc_status != ST_VALID &&
    readings.data.soc_status != ST_FALLBACK,
    readings.data.soc_tenths == '0 && readings.data.power_mode == MODE_SURVIVAL,
    "absent charge must read zero in survival mode")
  `BRS_ASSERT_SAME(a_ready_only_when_room, clk, rst,
    !samples.ready, q_count == CountW'(QueueDepth),
    "samples stalled while the queue has room")
  `BRS_ASSERT_NEXT(a_push_lands, clk, rst,
    samples.valid && samples.ready && q_count == '0, q_count != '0,
    "accepted sample did not enter the empty queue")

endmodule

`default_nettype wire
